[hdl/tksi_pkg.sv]
// tksi_pkg: shared types and constants for the top-k sorted insert unit
// holds beat field widths, status codes, controller states and the result record
// no dependencies
package tksi_pkg;

  localparam int KEY_W       = 64;
  localparam int SCORE_W     = 32;
  localparam int IDX_W       = 4;
  localparam int RANK_W      = 4;
  localparam int CNT_W       = 4;
  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 104;
  localparam int OUT_TUSER_W = 3;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_READ   = 1'b1;

  typedef enum logic [2:0] {
    STAT_INSERTED  = 3'd0,
    STAT_DUPLICATE = 3'd1,
    STAT_REJECTED  = 3'd2,
    STAT_READ_OK   = 3'd3,
    STAT_RANGE     = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_END,
    ST_DECIDE,
    ST_SHIFT,
    ST_SHIFT_END,
    ST_PLACE,
    ST_READ,
    ST_READ_WAIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    status_t                     status;
    logic [RANK_W-1:0]           rank;
    logic [KEY_W-1:0]            entry_key;
    logic signed [SCORE_W-1:0]   entry_score;
    logic [CNT_W-1:0]            entry_count;
  } res_t;

endpackage

[hdl/tksi_store.sv]
// tksi_store: entry memory of the top-k unit, one write and one read port
// read data is registered; no package needed
module tksi_store #(
  parameter int DEPTH = 10,
  parameter int WIDTH = 96,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hdl/tksi_ctrl.sv]
// tksi_ctrl: sequencer for the top-k unit, scans the entry memory, shifts and places
// uses tksi_pkg for states, status codes and the result record
module tksi_ctrl #(
  parameter int CAPACITY = 10,
  parameter int KEY_BITS = 64,
  parameter int AW       = 4,
  parameter int CW       = 4
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_mode,
  input  logic [tksi_pkg::KEY_W-1:0]       in_key,
  input  logic signed [tksi_pkg::SCORE_W-1:0] in_score,
  input  logic [tksi_pkg::IDX_W-1:0]       in_idx,
  output logic                             res_valid,
  input  logic                             res_ready,
  output tksi_pkg::res_t                   res,
  output logic                             mem_we,
  output logic [AW-1:0]                    mem_waddr,
  output logic [KEY_BITS+tksi_pkg::SCORE_W-1:0] mem_wdata,
  output logic [AW-1:0]                    mem_raddr,
  input  logic [KEY_BITS+tksi_pkg::SCORE_W-1:0] mem_rdata
);

  localparam int SW = tksi_pkg::SCORE_W;

  tksi_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic [KEY_BITS-1:0]    key_r, key_nxt;
  logic signed [SW-1:0]   score_r, score_nxt;
  logic [AW-1:0]          idx_r, idx_nxt;
  logic [AW-1:0]          ptr_r, ptr_nxt;
  logic                   cmp_v_r, cmp_v_nxt;
  logic [AW-1:0]          cmp_idx_r, cmp_idx_nxt;
  logic                   dup_r, dup_nxt;
  logic [CW-1:0]          pos_r, pos_nxt;
  logic signed [SW-1:0]   last_score_r, last_score_nxt;
  logic [AW-1:0]          sh_r, sh_nxt;
  logic                   shw_v_r, shw_v_nxt;
  logic [AW-1:0]          shw_addr_r, shw_addr_nxt;
  tksi_pkg::res_t         res_r, res_nxt;

  logic [KEY_BITS-1:0]    rd_key;
  logic signed [SW-1:0]   rd_score;
  logic                   full;
  logic                   take;
  logic [CW-1:0]          tgt;
  logic                   rd_oob;

  assign rd_key   = mem_rdata[KEY_BITS+SW-1:SW];
  assign rd_score = signed'(mem_rdata[SW-1:0]);
  assign full     = (count_r == CW'(CAPACITY));
  // room left, or strictly above the lowest entry
  assign take     = !full || (score_r > last_score_r);
  assign tgt      = full ? CW'(CAPACITY - 1) : count_r;
  assign rd_oob   = (in_idx >= tksi_pkg::IDX_W'(count_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tksi_pkg::ST_IDLE;
      count_r <= '0;
      cmp_v_r <= 1'b0;
      shw_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      cmp_v_r <= cmp_v_nxt;
      shw_v_r <= shw_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    score_r      <= score_nxt;
    idx_r        <= idx_nxt;
    ptr_r        <= ptr_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    dup_r        <= dup_nxt;
    pos_r        <= pos_nxt;
    last_score_r <= last_score_nxt;
    sh_r         <= sh_nxt;
    shw_addr_r   <= shw_addr_nxt;
    res_r        <= res_nxt;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tksi_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_mode == tksi_pkg::MODE_READ) begin
            state_nxt = rd_oob ? tksi_pkg::ST_DONE : tksi_pkg::ST_READ;
          end else begin
            state_nxt = (count_r == '0) ? tksi_pkg::ST_DECIDE : tksi_pkg::ST_SCAN;
          end
        end
      end
      tksi_pkg::ST_SCAN: begin
        if (CW'(ptr_r) == count_r - CW'(1)) begin
          state_nxt = tksi_pkg::ST_SCAN_END;
        end
      end
      tksi_pkg::ST_SCAN_END: state_nxt = tksi_pkg::ST_DECIDE;
      tksi_pkg::ST_DECIDE: begin
        if (dup_r || !take) begin
          state_nxt = tksi_pkg::ST_DONE;
        end else if (tgt > pos_r) begin
          state_nxt = tksi_pkg::ST_SHIFT;
        end else begin
          state_nxt = tksi_pkg::ST_PLACE;
        end
      end
      tksi_pkg::ST_SHIFT: begin
        if (CW'(sh_r) == pos_r + CW'(1)) begin
          state_nxt = tksi_pkg::ST_SHIFT_END;
        end
      end
      tksi_pkg::ST_SHIFT_END: state_nxt = tksi_pkg::ST_PLACE;
      tksi_pkg::ST_PLACE:     state_nxt = tksi_pkg::ST_DONE;
      tksi_pkg::ST_READ:      state_nxt = tksi_pkg::ST_READ_WAIT;
      tksi_pkg::ST_READ_WAIT: state_nxt = tksi_pkg::ST_DONE;
      tksi_pkg::ST_DONE: begin
        if (res_ready) begin
          state_nxt = tksi_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tksi_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory port
  always_comb begin
    count_nxt      = count_r;
    key_nxt        = key_r;
    score_nxt      = score_r;
    idx_nxt        = idx_r;
    ptr_nxt        = ptr_r;
    cmp_v_nxt      = 1'b0;
    cmp_idx_nxt    = cmp_idx_r;
    dup_nxt        = dup_r;
    pos_nxt        = pos_r;
    last_score_nxt = last_score_r;
    sh_nxt         = sh_r;
    shw_v_nxt      = 1'b0;
    shw_addr_nxt   = shw_addr_r;
    res_nxt        = res_r;
    mem_we         = 1'b0;
    mem_waddr      = shw_addr_r;
    mem_wdata      = mem_rdata;
    mem_raddr      = ptr_r;
    in_ready       = 1'b0;
    res_valid      = 1'b0;

    // compare stage, one entry per cycle behind the read
    if (cmp_v_r) begin
      if (rd_key == key_r && rd_score == score_r) begin
        dup_nxt = 1'b1;
      end
      if (rd_score >= score_r) begin
        pos_nxt = CW'(cmp_idx_r) + CW'(1);
      end
      last_score_nxt = rd_score;
    end

    // shift write lands in the cycle after its read
    if (shw_v_r) begin
      mem_we    = 1'b1;
      mem_waddr = shw_addr_r;
      mem_wdata = mem_rdata;
    end

    case (state_r)
      tksi_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          key_nxt   = in_key[KEY_BITS-1:0];
          score_nxt = in_score;
          idx_nxt   = in_idx[AW-1:0];
          ptr_nxt   = '0;
          dup_nxt   = 1'b0;
          pos_nxt   = '0;
          res_nxt             = '0;
          res_nxt.entry_count = tksi_pkg::CNT_W'(count_r);
          res_nxt.status      = tksi_pkg::STAT_RANGE;
        end
      end
      tksi_pkg::ST_SCAN: begin
        mem_raddr   = ptr_r;
        cmp_v_nxt   = 1'b1;
        cmp_idx_nxt = ptr_r;
        ptr_nxt     = ptr_r + AW'(1);
      end
      tksi_pkg::ST_DECIDE: begin
        if (dup_r) begin
          res_nxt.status = tksi_pkg::STAT_DUPLICATE;
        end else if (take) begin
          res_nxt.status = tksi_pkg::STAT_INSERTED;
          res_nxt.rank   = tksi_pkg::RANK_W'(pos_r);
          sh_nxt         = tgt[AW-1:0];
          if (!full) begin
            count_nxt           = count_r + CW'(1);
            res_nxt.entry_count = tksi_pkg::CNT_W'(count_r + CW'(1));
          end
        end else begin
          res_nxt.status = tksi_pkg::STAT_REJECTED;
        end
      end
      tksi_pkg::ST_SHIFT: begin
        mem_raddr    = sh_r - AW'(1);
        shw_v_nxt    = 1'b1;
        shw_addr_nxt = sh_r;
        sh_nxt       = sh_r - AW'(1);
      end
      tksi_pkg::ST_PLACE: begin
        mem_we    = 1'b1;
        mem_waddr = pos_r[AW-1:0];
        mem_wdata = {key_r, score_r};
      end
      tksi_pkg::ST_READ: begin
        mem_raddr = idx_r;
      end
      tksi_pkg::ST_READ_WAIT: begin
        res_nxt.status      = tksi_pkg::STAT_READ_OK;
        res_nxt.rank        = tksi_pkg::RANK_W'(idx_r);
        res_nxt.entry_key   = tksi_pkg::KEY_W'(rd_key);
        res_nxt.entry_score = rd_score;
      end
      tksi_pkg::ST_DONE: begin
        res_valid = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign res = res_r;

  // the shift write and the placement never share a cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    !(shw_v_r && state_r == tksi_pkg::ST_PLACE))
    else $error("shift write collides with placement");

  // the memory is written only while an insert is being carried out
  assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == tksi_pkg::ST_SHIFT || state_r == tksi_pkg::ST_SHIFT_END ||
                state_r == tksi_pkg::ST_PLACE))
    else $error("memory write outside an insert");

  // fill count only ever grows by one, and never past the capacity
  assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && count_r != $past(count_r)) |->
      (count_r == $past(count_r) + CW'(1) && count_r <= CW'(CAPACITY)))
    else $error("fill count moved wrongly");

  // a placement always follows a decision to insert
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tksi_pkg::ST_PLACE) |=>
      (state_r == tksi_pkg::ST_DONE && res_r.status == tksi_pkg::STAT_INSERTED))
    else $error("placement without an insert result");

endmodule

[hdl/top_k_sorted_insert_unit.sv]
// top_k_sorted_insert_unit: leaderboard of the best scores kept in descending order
// instantiates tksi_ctrl and tksi_store, uses tksi_pkg
//
// An insert reads the stored entries one a cycle through the single read port of the
// entry memory, then moves the entries below the new place down one slot (one a cycle,
// read and write overlapped) and writes the new entry. An insert into an empty list skips
// the scan, and a duplicate or a rejected entry moves and writes nothing. A read of an
// index beyond the stored entries goes to the result without reading the memory. Items
// are handled one at a time; the result sits in an output register, so the next beat is
// taken while it waits. The store starts empty.
module top_k_sorted_insert_unit #(
  parameter int CAPACITY = 10,
  parameter int KEY_BITS = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // [63:0] player_key, [95:64] score, [99:96] read_index, [103:100] zero
  input  logic [tksi_pkg::IN_TDATA_W-1:0]      in_tdata,
  // [0] mode
  input  logic                                 in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [3:0] rank, [67:4] entry_key, [99:68] entry_score, [103:100] entry_count
  output logic [tksi_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // [2:0] status
  output logic [tksi_pkg::OUT_TUSER_W-1:0]     out_tuser
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int MW = KEY_BITS + tksi_pkg::SCORE_W;

  logic                 res_valid;
  logic                 res_ready;
  tksi_pkg::res_t       res;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [MW-1:0]        mem_wdata;
  logic [AW-1:0]        mem_raddr;
  logic [MW-1:0]        mem_rdata;

  logic                 out_valid_r, out_valid_nxt;
  tksi_pkg::res_t       out_res_r, out_res_nxt;

  tksi_ctrl #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_mode   (in_tuser),
    .in_key    (in_tdata[63:0]),
    .in_score  (signed'(in_tdata[95:64])),
    .in_idx    (in_tdata[99:96]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  tksi_store #(
    .DEPTH (CAPACITY),
    .WIDTH (MW),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // output register takes a new result when empty or being drained
  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.entry_count, out_res_r.entry_score,
                       out_res_r.entry_key, out_res_r.rank};
  assign out_tuser  = out_res_r.status;

endmodule

[tb/leaderboard_checker.sv]
// leaderboard_checker: watches both streams of top_k_sorted_insert_unit, predicts each result
// from its own copy of the ranked list and compares the result beats field by field
// depends on tksi_pkg
module leaderboard_checker #(
  parameter int CAPACITY = 10,
  parameter int KEY_BITS = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  input  logic                                in_tready,
  input  logic [tksi_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                                in_tuser,
  input  logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic [tksi_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic [tksi_pkg::OUT_TUSER_W-1:0]    out_tuser,
  output int                                  fail_count,
  output int                                  results_pending,
  output logic [4:0][31:0]                    status_tally
);
  timeunit 1ns;
  timeprecision 1ps;

  import tksi_pkg::*;

  localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - KEY_BITS);

  logic [KEY_W-1:0]          board_keys [CAPACITY];
  logic signed [SCORE_W-1:0] board_scores [CAPACITY];
  int                        board_len;
  res_t                      pending_results [$];
  res_t                      want;
  res_t                      fresh;
  int                        mismatches;
  logic [4:0][31:0]          hits;

  // one step of the ranked list: insert or read, returns the result it gives
  function automatic res_t leaderboard_step(input logic mode,
                                            input logic [KEY_W-1:0] key_in,
                                            input logic signed [SCORE_W-1:0] score,
                                            input logic [IDX_W-1:0] idx);
    res_t             r;
    logic [KEY_W-1:0] key;
    logic             dup;
    int               slot;
    int               last;
    r = '0;
    if (mode == MODE_INSERT) begin
      key  = key_in & KEY_MASK;
      dup  = 1'b0;
      slot = 0;
      for (int i = 0; i < board_len; i++) begin
        if (board_keys[i] == key && board_scores[i] == score) dup = 1'b1;
        // equal scores keep arrival order
        if (board_scores[i] >= score) slot = i + 1;
      end
      if (dup) begin
        r.status = STAT_DUPLICATE;
      end else if (board_len < CAPACITY || score > board_scores[CAPACITY-1]) begin
        last = (board_len < CAPACITY) ? board_len : CAPACITY - 1;
        for (int i = last; i > slot; i--) begin
          board_keys[i]   = board_keys[i-1];
          board_scores[i] = board_scores[i-1];
        end
        board_keys[slot]   = key;
        board_scores[slot] = score;
        if (board_len < CAPACITY) board_len++;
        r.status = STAT_INSERTED;
        r.rank   = RANK_W'(slot);
      end else begin
        r.status = STAT_REJECTED;
      end
    end else if (int'(idx) < board_len) begin
      r.status      = STAT_READ_OK;
      r.rank        = idx;
      r.entry_key   = board_keys[idx];
      r.entry_score = board_scores[idx];
    end else begin
      r.status = STAT_RANGE;
    end
    r.entry_count = CNT_W'(board_len);
    return r;
  endfunction

  task automatic check_field(input string field, input logic [KEY_W-1:0] exp_val,
                             input logic [KEY_W-1:0] act_val);
    if (act_val !== exp_val) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, exp_val, act_val);
      mismatches++;
    end
  endtask

  initial begin
    mismatches = 0;
    hits       = '0;
    board_len  = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      board_len = 0;
      pending_results.delete();
    end else begin
      // result beats first: a result never belongs to the beat taken at the same edge
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result beat, status %0d rank %0d", $time, out_tuser,
                   out_tdata[3:0]);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("status", want.status, out_tuser);
          check_field("rank", want.rank, out_tdata[3:0]);
          check_field("entry_key", want.entry_key, out_tdata[67:4]);
          check_field("entry_score", {32'd0, want.entry_score}, {32'd0, out_tdata[99:68]});
          check_field("entry_count", want.entry_count, out_tdata[103:100]);
          hits[want.status] = hits[want.status] + 1;
        end
      end
      if (in_tvalid && in_tready) begin
        fresh = leaderboard_step(in_tuser, in_tdata[63:0], in_tdata[95:64], in_tdata[99:96]);
        pending_results.push_back(fresh);
      end
    end
    results_pending <= pending_results.size();
    fail_count      <= mismatches;
    status_tally    <= hits;
  end

endmodule

[tb/testbench.sv]
// testbench: drives top_k_sorted_insert_unit with directed and random beats under random stalls
// and gives the verdict; prediction and comparison sit in leaderboard_checker
// depends on tksi_pkg, top_k_sorted_insert_unit and leaderboard_checker
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tksi_pkg::*;

  localparam int CAPACITY     = 10;
  localparam int KEY_BITS     = 64;
  localparam int RANDOM_ITEMS = 1800;
  localparam int STILL_LIMIT  = 2000;
  localparam int TAIL_ITEMS   = 200;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_tvalid = 1'b0;
  logic                     in_tready;
  logic [IN_TDATA_W-1:0]    in_tdata = '0;
  logic                     in_tuser = MODE_INSERT;
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]   out_tdata;
  logic [OUT_TUSER_W-1:0]   out_tuser;

  int                       fail_count;
  int                       results_pending;
  logic [4:0][31:0]         status_tally;

  logic                     quiet = 1'b0;
  logic                     rx_quiet = 1'b0;
  int                       stall_left = 0;
  int                       still_cycles = 0;

  logic [KEY_W-1:0]         recent_keys [$];
  logic [SCORE_W-1:0]       recent_scores [$];

  always #5 clk = ~clk;

  top_k_sorted_insert_unit #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  leaderboard_checker #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .fail_count      (fail_count),
    .results_pending (results_pending),
    .status_tally    (status_tally)
  );

  // result side back-pressure in bursts of random length
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!rx_quiet && $urandom_range(0, 7) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 14);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      still_cycles <= 0;
    end else begin
      still_cycles <= still_cycles + 1;
      if (still_cycles == STILL_LIMIT) begin
        $display("%0t: no beat for %0d cycles", $time, STILL_LIMIT);
        $display("top_k_sorted_insert_unit regression: fail");
        $finish;
      end
    end
  end

  task automatic send_beat(input logic mode, input logic [KEY_W-1:0] key,
                           input logic [SCORE_W-1:0] score, input logic [IDX_W-1:0] idx);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 15);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {4'd0, idx, score, key};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (results_pending != 0);
  endtask

  initial begin
    int               pick;
    int               j;
    int               jitter;
    int               score_level;
    logic             calm;
    logic             mode;
    logic [KEY_W-1:0] key;
    logic [SCORE_W-1:0] score;
    logic [IDX_W-1:0] idx;

    score_level = -1000;
    calm        = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list, then extremes, ties, a full list and its edge cases
    send_beat(MODE_READ,   '0, '0, 4'd0);
    send_beat(MODE_READ,   '0, '0, 4'd15);
    send_beat(MODE_INSERT, '1, 32'h7FFF_FFFF, 4'd0);
    send_beat(MODE_INSERT, '0, 32'h8000_0000, 4'd15);
    send_beat(MODE_INSERT, '1, 32'h7FFF_FFFF, 4'd0);
    send_beat(MODE_INSERT, 64'h5555_5555_5555_5555, 32'd0, 4'd0);
    send_beat(MODE_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 32'd0, 4'd0);
    send_beat(MODE_READ,   '1, 32'hFFFF_FFFF, 4'd1);
    send_beat(MODE_READ,   '0, '0, 4'd3);
    send_beat(MODE_INSERT, 64'd11, 32'hFFFF_FFFF, 4'd0);
    send_beat(MODE_INSERT, 64'd12, 32'd1, 4'd0);
    send_beat(MODE_INSERT, 64'd13, 32'd100, 4'd0);
    send_beat(MODE_INSERT, 64'd14, -32'sd100, 4'd0);
    send_beat(MODE_INSERT, 64'd15, 32'd7, 4'd0);
    send_beat(MODE_INSERT, 64'd16, 32'd7, 4'd0);
    // list is full now: equal to the last entry is turned away, one above displaces it
    send_beat(MODE_INSERT, 64'd1, 32'h8000_0000, 4'd0);
    send_beat(MODE_INSERT, 64'd2, 32'h8000_0001, 4'd0);
    send_beat(MODE_INSERT, '0, 32'h8000_0000, 4'd0);
    send_beat(MODE_INSERT, '1, 32'h7FFF_FFFF, 4'd0);
    send_beat(MODE_READ,   '0, '0, 4'd9);
    send_beat(MODE_READ,   '0, '0, 4'd10);
    send_beat(MODE_READ,   '0, '0, 4'd15);
    drain_results();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 150 == 0) calm = ($urandom_range(0, 3) == 0);
      quiet = calm || (n >= RANDOM_ITEMS - TAIL_ITEMS);
      rx_quiet <= quiet;
      if (n == RANDOM_ITEMS / 2) drain_results();

      pick  = $urandom_range(0, 99);
      mode  = MODE_INSERT;
      key   = {$urandom, $urandom};
      score = $urandom;
      idx   = $urandom_range(0, 15);
      if (pick < 25) begin
        mode = MODE_READ;
      end else if (pick < 35 && recent_keys.size() != 0) begin
        // re-offer a pair seen lately, mostly a duplicate while it stays on the list
        j     = $urandom_range(0, recent_keys.size() - 1);
        key   = recent_keys[j];
        score = recent_scores[j];
      end else if (pick >= 50) begin
        // slowly rising scores from a small key pool keep displacing the tail
        jitter      = $urandom_range(0, 8);
        score       = SCORE_W'(score_level + jitter - 4);
        key         = KEY_W'($urandom_range(0, 7));
        score_level = score_level + int'($urandom_range(0, 3));
      end
      if (mode == MODE_INSERT) begin
        recent_keys.push_back(key);
        recent_scores.push_back(score);
        if (recent_keys.size() > 16) begin
          recent_keys.pop_front();
          recent_scores.pop_front();
        end
      end
      send_beat(mode, key, score, idx);
    end

    drain_results();
    repeat (40) @(posedge clk);

    $display("checked %0d results: %0d placed, %0d duplicates, %0d turned away,",
             status_tally[STAT_INSERTED] + status_tally[STAT_DUPLICATE]
             + status_tally[STAT_REJECTED] + status_tally[STAT_READ_OK]
             + status_tally[STAT_RANGE],
             status_tally[STAT_INSERTED], status_tally[STAT_DUPLICATE],
             status_tally[STAT_REJECTED]);
    $display("%0d reads of stored entries and %0d reads past the end of the list",
             status_tally[STAT_READ_OK], status_tally[STAT_RANGE]);
    if (results_pending != 0) $display("%0d results never arrived", results_pending);
    if (fail_count == 0 && results_pending == 0) begin
      $display("top_k_sorted_insert_unit regression: pass");
    end else begin
      $display("top_k_sorted_insert_unit regression: fail");
    end
    $finish;
  end

endmodule

[files.f]
hdl/tksi_pkg.sv
hdl/tksi_store.sv
hdl/tksi_ctrl.sv
hdl/top_k_sorted_insert_unit.sv
tb/leaderboard_checker.sv
tb/testbench.sv
